// ===== design/nau_pkg.sv =====
// Shared types and codes for the accumulator update block.
// No dependencies; imported by the top level.
`default_nettype none

package nau_pkg;

   typedef enum logic [2:0] {
      REQ_WR_WEIGHT,
      REQ_WR_BUCKET_WEIGHT,
      REQ_LOAD_ACC,
      REQ_LOAD_BUCKET_ACC,
      REQ_ADD,
      REQ_REMOVE,
      REQ_RD_ACC,
      REQ_RD_BUCKET
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_RANGE,
      ST_OVERFLOW
   } status_type;

   localparam int COL_W   = 16;
   localparam int SUM_W   = 32;
   localparam int FEAT_W  = 16;
   localparam int ENTRY_W = FEAT_W + 1;

endpackage

`default_nettype wire

// ===== design/nau_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module nau_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/nnue_accumulator_update.sv =====
// Writes, loads, add/remove and rejected batches pass S_EXEC and S_RESP; in-range reads
// add S_RDWAIT. An applied batch runs S_PFETCH, S_PWAIT and S_SWEEP per pending entry,
// one read-modify-write per cycle through the shared adder and accumulator RAMs.
// One word in flight; ready returns in the cycle the response is registered, and S_RESP
// holds a new response while an earlier one still waits in the output register.
// Synchronous reset clears control and accumulator valid bits; weights are undefined.
`default_nettype none

module nnue_accumulator_update
   import nau_pkg::*;
#(
   parameter int FEATURE_COUNT = 1024,
   parameter int ROW_WIDTH     = 128,
   parameter int BUCKET_COUNT  = 8,
   parameter int DELTA_LIMIT   = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_type,
   input  wire logic [15:0]        req_feature_index,
   input  wire logic [7:0]         req_element_index,
   input  wire logic signed [31:0] req_data_value,
   input  wire logic               req_batch_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_read_value,
   output logic                    rsp_batch_applied
);

   localparam int ROW_DEPTH = FEATURE_COUNT * ROW_WIDTH;
   localparam int BW_DEPTH  = FEATURE_COUNT * BUCKET_COUNT;
   localparam int RA_W      = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
   localparam int BWA_W     = (BW_DEPTH > 1) ? $clog2(BW_DEPTH) : 1;
   localparam int CA        = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
   localparam int BA        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int PW        = (DELTA_LIMIT > 1) ? $clog2(DELTA_LIMIT) : 1;
   localparam int CW        = $clog2(DELTA_LIMIT + 1);
   localparam int SMAX      = (ROW_WIDTH > BUCKET_COUNT) ? ROW_WIDTH : BUCKET_COUNT;
   localparam int SW        = $clog2(SMAX + 1);
   localparam logic [SW-1:0] COL_LIMIT = SW'(ROW_WIDTH);
   localparam logic [SW-1:0] BKT_LIMIT = SW'(BUCKET_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_PFETCH,
      S_PWAIT,
      S_SWEEP,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   req_kind_type         kind_ff, kind_in;
   logic [FEAT_W-1:0]    feat_ff, feat_in;
   logic [7:0]           elem_ff, elem_in;
   logic [SUM_W-1:0]     data_ff, data_in;
   logic                 last_ff, last_in;
   logic [CW-1:0]        count_ff, count_in;
   status_type           fault_ff, fault_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [RA_W-1:0]      row_base_ff, row_base_in;
   logic [BWA_W-1:0]     bkt_base_ff, bkt_base_in;
   logic                 remove_ff, remove_in;
   logic [SW-1:0]        issue_ff, issue_in;
   logic                 phase_bkt_ff, phase_bkt_in;
   logic                 pipe_v_ff, pipe_v_in;
   logic [SW-1:0]        pipe_idx_ff, pipe_idx_in;
   status_type           res_status_ff, res_status_in;
   logic [SUM_W-1:0]     res_read_ff, res_read_in;
   logic                 res_applied_ff, res_applied_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SUM_W-1:0]     rsp_read_ff, rsp_read_in;
   logic                 rsp_applied_ff, rsp_applied_in;

   logic                 col_valid_ff [ROW_WIDTH];
   logic                 bkt_valid_ff [BUCKET_COUNT];
   logic                 col_rd_valid_ff;
   logic                 bkt_rd_valid_ff;

   logic                 row_wr_en;
   logic [RA_W-1:0]      row_wr_addr, row_rd_addr;
   logic [COL_W-1:0]     row_rd_data;
   logic                 bw_wr_en;
   logic [BWA_W-1:0]     bw_wr_addr, bw_rd_addr;
   logic [SUM_W-1:0]     bw_rd_data;
   logic                 col_wr_en;
   logic [CA-1:0]        col_wr_addr, col_rd_addr;
   logic [COL_W-1:0]     col_wr_data, col_rd_data;
   logic                 bs_wr_en;
   logic [BA-1:0]        bs_wr_addr, bs_rd_addr;
   logic [SUM_W-1:0]     bs_wr_data, bs_rd_data;
   logic                 pend_wr_en;
   logic [PW-1:0]        pend_wr_addr, pend_rd_addr;
   logic [ENTRY_W-1:0]   pend_wr_data, pend_rd_data;

   logic                 feat_ok, col_ok, bkt_ok, room;
   logic [31:0]          row_base_w, bkt_base_w;
   logic [31:0]          prow_base_w, pbkt_base_w;
   logic [SUM_W-1:0]     op_a, op_b, sum_res;
   logic [COL_W-1:0]     col_sum_rd;
   logic [SUM_W-1:0]     bkt_sum_rd;
   status_type           fault_new;
   logic [CW-1:0]        count_new;
   logic                 accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   assign feat_ok = ({16'b0, feat_ff} < 32'(FEATURE_COUNT));
   assign col_ok  = ({24'b0, elem_ff} < 32'(ROW_WIDTH));
   assign bkt_ok  = ({24'b0, elem_ff} < 32'(BUCKET_COUNT));
   assign room    = (32'(count_ff) < 32'(DELTA_LIMIT));

   assign row_base_w  = 32'(feat_ff) * 32'(ROW_WIDTH);
   assign bkt_base_w  = 32'(feat_ff) * 32'(BUCKET_COUNT);
   assign prow_base_w = 32'(pend_rd_data[FEAT_W-1:0]) * 32'(ROW_WIDTH);
   assign pbkt_base_w = 32'(pend_rd_data[FEAT_W-1:0]) * 32'(BUCKET_COUNT);

   assign col_sum_rd = col_rd_valid_ff ? col_rd_data : '0;
   assign bkt_sum_rd = bkt_rd_valid_ff ? bs_rd_data : '0;

   // shared accumulate unit
   assign op_a    = phase_bkt_ff ? bkt_sum_rd : {16'b0, col_sum_rd};
   assign op_b    = phase_bkt_ff ? bw_rd_data : {16'b0, row_rd_data};
   assign sum_res = remove_ff ? (op_a - op_b) : (op_a + op_b);

   assign row_rd_addr  = row_base_ff + RA_W'(issue_ff);
   assign bw_rd_addr   = bkt_base_ff + BWA_W'(issue_ff);
   assign col_rd_addr  = (state_ff == S_EXEC) ? elem_ff[CA-1:0] : issue_ff[CA-1:0];
   assign bs_rd_addr   = (state_ff == S_EXEC) ? elem_ff[BA-1:0] : issue_ff[BA-1:0];
   assign pend_rd_addr = idx_ff[PW-1:0];
   assign pend_wr_addr = count_ff[PW-1:0];
   assign pend_wr_data = {(kind_ff == REQ_REMOVE), feat_ff};
   assign row_wr_addr  = RA_W'(row_base_w + 32'(elem_ff));
   assign bw_wr_addr   = BWA_W'(bkt_base_w + 32'(elem_ff));

   always_comb begin
      fault_new = fault_ff;
      count_new = count_ff;
      pend_wr_en = 1'b0;
      if (!feat_ok) begin
         if (fault_ff == ST_OK) fault_new = ST_RANGE;
      end else if (!room) begin
         if (fault_ff == ST_OK) fault_new = ST_OVERFLOW;
      end else begin
         pend_wr_en = (state_ff == S_EXEC) &&
                      ((kind_ff == REQ_ADD) || (kind_ff == REQ_REMOVE));
         count_new  = count_ff + CW'(1);
      end
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      feat_in        = feat_ff;
      elem_in        = elem_ff;
      data_in        = data_ff;
      last_in        = last_ff;
      count_in       = count_ff;
      fault_in       = fault_ff;
      idx_in         = idx_ff;
      row_base_in    = row_base_ff;
      bkt_base_in    = bkt_base_ff;
      remove_in      = remove_ff;
      issue_in       = issue_ff;
      phase_bkt_in   = phase_bkt_ff;
      pipe_v_in      = 1'b0;
      pipe_idx_in    = issue_ff;
      res_status_in  = res_status_ff;
      res_read_in    = res_read_ff;
      res_applied_in = res_applied_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_applied_in = rsp_applied_ff;
      row_wr_en      = 1'b0;
      bw_wr_en       = 1'b0;
      col_wr_en      = 1'b0;
      col_wr_addr    = pipe_idx_ff[CA-1:0];
      col_wr_data    = sum_res[COL_W-1:0];
      bs_wr_en       = 1'b0;
      bs_wr_addr     = pipe_idx_ff[BA-1:0];
      bs_wr_data     = sum_res;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_kind_type'(req_type);
               feat_in  = req_feature_index;
               elem_in  = req_element_index;
               data_in  = req_data_value;
               last_in  = req_batch_last;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in  = ST_OK;
            res_read_in    = '0;
            res_applied_in = 1'b0;
            state_in       = S_RESP;
            case (kind_ff)
               REQ_WR_WEIGHT: begin
                  row_wr_en = feat_ok && col_ok;
                  if (!(feat_ok && col_ok)) res_status_in = ST_RANGE;
               end
               REQ_WR_BUCKET_WEIGHT: begin
                  bw_wr_en = feat_ok && bkt_ok;
                  if (!(feat_ok && bkt_ok)) res_status_in = ST_RANGE;
               end
               REQ_LOAD_ACC: begin
                  col_wr_en   = col_ok;
                  col_wr_addr = elem_ff[CA-1:0];
                  col_wr_data = data_ff[COL_W-1:0];
                  if (!col_ok) res_status_in = ST_RANGE;
               end
               REQ_LOAD_BUCKET_ACC: begin
                  bs_wr_en   = bkt_ok;
                  bs_wr_addr = elem_ff[BA-1:0];
                  bs_wr_data = data_ff;
                  if (!bkt_ok) res_status_in = ST_RANGE;
               end
               REQ_ADD, REQ_REMOVE: begin
                  res_status_in = fault_new;
                  count_in      = count_new;
                  fault_in      = fault_new;
                  if (last_ff) begin
                     if (fault_new == ST_OK) begin
                        idx_in   = '0;
                        state_in = S_PFETCH;
                     end else begin
                        count_in = '0;
                        fault_in = ST_OK;
                     end
                  end
               end
               REQ_RD_ACC: begin
                  if (col_ok) state_in = S_RDWAIT;
                  else res_status_in = ST_RANGE;
               end
               REQ_RD_BUCKET: begin
                  if (bkt_ok) state_in = S_RDWAIT;
                  else res_status_in = ST_RANGE;
               end
               default: res_status_in = ST_RANGE;
            endcase
         end
         S_RDWAIT: begin
            if (kind_ff == REQ_RD_ACC) begin
               res_read_in = {{16{col_sum_rd[COL_W-1]}}, col_sum_rd};
            end else begin
               res_read_in = bkt_sum_rd;
            end
            state_in = S_RESP;
         end
         S_PFETCH: begin
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            row_base_in  = RA_W'(prow_base_w);
            bkt_base_in  = BWA_W'(pbkt_base_w);
            remove_in    = pend_rd_data[ENTRY_W-1];
            issue_in     = '0;
            phase_bkt_in = 1'b0;
            state_in     = S_SWEEP;
         end
         S_SWEEP: begin
            if (issue_ff != (phase_bkt_ff ? BKT_LIMIT : COL_LIMIT)) begin
               pipe_v_in = 1'b1;
               issue_in  = issue_ff + SW'(1);
            end
            if (pipe_v_ff) begin
               col_wr_en = !phase_bkt_ff;
               bs_wr_en  = phase_bkt_ff;
            end
            if ((issue_ff == (phase_bkt_ff ? BKT_LIMIT : COL_LIMIT)) && !pipe_v_ff) begin
               if (!phase_bkt_ff) begin
                  phase_bkt_in = 1'b1;
                  issue_in     = '0;
               end else if (idx_ff + CW'(1) == count_ff) begin
                  res_applied_in = 1'b1;
                  count_in       = '0;
                  fault_in       = ST_OK;
                  state_in       = S_RESP;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_PFETCH;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_read_in    = res_read_ff;
               rsp_applied_in = res_applied_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         fault_ff     <= ST_OK;
         rsp_valid_ff <= 1'b0;
         pipe_v_ff    <= 1'b0;
         for (int i = 0; i < ROW_WIDTH; i++) col_valid_ff[i] <= 1'b0;
         for (int i = 0; i < BUCKET_COUNT; i++) bkt_valid_ff[i] <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         pipe_v_ff    <= pipe_v_in;
         if (col_wr_en) col_valid_ff[col_wr_addr] <= 1'b1;
         if (bs_wr_en) bkt_valid_ff[bs_wr_addr] <= 1'b1;
      end
      kind_ff         <= kind_in;
      feat_ff         <= feat_in;
      elem_ff         <= elem_in;
      data_ff         <= data_in;
      last_ff         <= last_in;
      idx_ff          <= idx_in;
      row_base_ff     <= row_base_in;
      bkt_base_ff     <= bkt_base_in;
      remove_ff       <= remove_in;
      issue_ff        <= issue_in;
      phase_bkt_ff    <= phase_bkt_in;
      pipe_idx_ff     <= pipe_idx_in;
      res_status_ff   <= res_status_in;
      res_read_ff     <= res_read_in;
      res_applied_ff  <= res_applied_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_read_ff     <= rsp_read_in;
      rsp_applied_ff  <= rsp_applied_in;
      col_rd_valid_ff <= col_valid_ff[col_rd_addr];
      bkt_rd_valid_ff <= bkt_valid_ff[bs_rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_read_ff;
   assign rsp_batch_applied = rsp_applied_ff;

   nau_ram #(.WIDTH(COL_W), .DEPTH(ROW_DEPTH)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (data_ff[COL_W-1:0]),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   nau_ram #(.WIDTH(SUM_W), .DEPTH(BW_DEPTH)) u_bkt_weight_ram (
      .clock   (clock),
      .wr_en   (bw_wr_en),
      .wr_addr (bw_wr_addr),
      .wr_data (data_ff),
      .rd_addr (bw_rd_addr),
      .rd_data (bw_rd_data)
   );

   nau_ram #(.WIDTH(COL_W), .DEPTH(ROW_WIDTH)) u_col_sum_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_wr_addr),
      .wr_data (col_wr_data),
      .rd_addr (col_rd_addr),
      .rd_data (col_rd_data)
   );

   nau_ram #(.WIDTH(SUM_W), .DEPTH(BUCKET_COUNT)) u_bkt_sum_ram (
      .clock   (clock),
      .wr_en   (bs_wr_en),
      .wr_addr (bs_wr_addr),
      .wr_data (bs_wr_data),
      .rd_addr (bs_rd_addr),
      .rd_data (bs_rd_data)
   );

   nau_ram #(.WIDTH(ENTRY_W), .DEPTH(DELTA_LIMIT)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_addr (pend_rd_addr),
      .rd_data (pend_rd_data)
   );

`ifndef SYNTH
   a_applied_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_batch_applied |-> rsp_status == ST_OK)
      else $error("applied batch reported a fault");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DELTA_LIMIT))
      else $error("pending count beyond limit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accept");

   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_value != 0 |-> rsp_status == ST_OK && !rsp_batch_applied)
      else $error("read value on faulted or apply word");
`endif

endmodule

`default_nettype wire
